// File: rtl/mt_pkg.sv
// package: constants, operation codes, control structs and tempering for the mt19937 block
package mt_pkg;

  // state geometry
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;

  // generator constants
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  // operation codes of an input item
  typedef enum logic {
    OP_NEXT = 1'b0,
    OP_SEED = 1'b1
  } op_e;

  // commands from controller to datapath
  typedef struct packed {
    logic fill_start;  // load seed, clear fill counter and index
    logic sel_auto;    // take the seed from the auto seed register
    logic fill_step;   // write one initialisation word
    logic rd_nxt;      // read the word after the current one
    logic rd_far;      // read the word at the twist offset
    logic commit;      // write twisted word, load result register
  } mt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_last;   // current fill word is the last one
    logic out_free;    // result register can take a new word
  } mt_sts_t;

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: rtl/mt_if.sv
// channel interfaces: input items, result items and the auto seed write port

interface mt_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed_value;
  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface mt_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface mt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mt_ctrl.sv
// controller: sequences seeding sweeps and the accept, far-read and twist steps of each next item
module mt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_operation_i,
  output logic           in_ready_o,
  input  mt_pkg::mt_sts_t sts_i,
  output mt_pkg::mt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_TWIST
  } state_e;

  state_e state_q;
  logic   seeded_q;
  logic   pending_q;
  logic   accept;
  logic   is_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_next    = (mt_pkg::op_e'(in_operation_i) == mt_pkg::OP_NEXT);

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.fill_start = accept && (!is_next || !seeded_q);
    cmd_o.sel_auto   = is_next;
    cmd_o.fill_step  = (state_q == ST_FILL);
    cmd_o.rd_nxt     = (accept && is_next && seeded_q) || (state_q == ST_RD_NXT);
    cmd_o.rd_far     = (state_q == ST_RD_FAR);
    cmd_o.commit     = (state_q == ST_TWIST) && sts_i.out_free;
  end

  // state and seeding flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seeded_q  <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_o.fill_start) begin
              state_q   <= ST_FILL;
              pending_q <= is_next;
              seeded_q  <= 1'b1;
            end else begin
              state_q <= ST_RD_FAR;
            end
          end
        end
        ST_FILL: begin
          if (sts_i.fill_last) begin
            state_q <= pending_q ? ST_RD_NXT : ST_IDLE;
          end
        end
        ST_RD_NXT: begin
          state_q <= ST_RD_FAR;
        end
        ST_RD_FAR: begin
          state_q <= ST_TWIST;
        end
        ST_TWIST: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mt_dpath.sv
// datapath: state memory, seeding recurrence, twist, tempering and result register
module mt_dpath #(
  parameter int unsigned STATE_WORDS  = mt_pkg::STATE_WORDS,
  parameter int unsigned TWIST_OFFSET = mt_pkg::TWIST_OFFSET
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mt_pkg::mt_cmd_t cmd_i,
  output mt_pkg::mt_sts_t sts_o,
  input  logic [31:0]     seed_value_i,
  input  logic            cfg_valid_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [31:0]     random_word_o
);

  localparam int unsigned IdxW = $clog2(STATE_WORDS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(STATE_WORDS - 1);
  localparam logic [IdxW:0]   WordsW  = (IdxW + 1)'(STATE_WORDS);
  localparam logic [IdxW:0]   OffsW   = (IdxW + 1)'(TWIST_OFFSET);

  logic [31:0]     mem_q [STATE_WORDS];
  logic [31:0]     rd_q;
  logic [31:0]     auto_seed_q;
  logic [31:0]     v_q;
  logic [31:0]     cur_q;
  logic [31:0]     nxt_word_q;
  logic [31:0]     y_q;
  logic [31:0]     word_q;
  logic            out_valid_q;
  logic [IdxW-1:0] fill_cnt_q;
  logic [IdxW-1:0] idx_q;

  logic [IdxW-1:0] nxt_idx;
  logic [IdxW:0]   far_sum;
  logic [IdxW-1:0] far_idx;
  logic [31:0]     v_mix;
  logic [31:0]     v_next;
  logic [31:0]     fill_word;
  logic [31:0]     twist_word;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [31:0]     mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;

  // neighbour addresses around the current index
  assign nxt_idx = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign far_sum = {1'b0, idx_q} + OffsW;
  assign far_idx = (far_sum >= WordsW) ? IdxW'(far_sum - WordsW) : far_sum[IdxW-1:0];

  // initialisation recurrence, one word a cycle
  assign v_mix     = v_q ^ (v_q >> 30);
  assign v_next    = mt_pkg::SEED_MULT * v_mix + 32'(fill_cnt_q);
  assign fill_word = (fill_cnt_q == '0) ? v_q : v_next;

  // twist of the current word
  assign twist_word = rd_q ^ (y_q >> 1) ^ (y_q[0] ? mt_pkg::TWIST_MATRIX : 32'h0);

  // memory port selection
  assign mem_we    = cmd_i.fill_step || cmd_i.commit;
  assign mem_waddr = cmd_i.fill_step ? fill_cnt_q : idx_q;
  assign mem_wdata = cmd_i.fill_step ? fill_word : twist_word;
  assign mem_re    = cmd_i.rd_nxt || cmd_i.rd_far;
  assign mem_raddr = cmd_i.rd_far ? far_idx : nxt_idx;

  // state memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // status
  assign sts_o.fill_last = (fill_cnt_q == LastIdx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_seed_q <= mt_pkg::DEFAULT_SEED;
      out_valid_q <= 1'b0;
      fill_cnt_q  <= '0;
      idx_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        auto_seed_q <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.fill_start) begin
        fill_cnt_q <= '0;
        idx_q      <= '0;
      end else begin
        if (cmd_i.fill_step && !sts_o.fill_last) begin
          fill_cnt_q <= fill_cnt_q + 1'b1;
        end
        if (cmd_i.commit) begin
          idx_q <= nxt_idx;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_start) begin
      v_q   <= cmd_i.sel_auto ? auto_seed_q : seed_value_i;
      cur_q <= cmd_i.sel_auto ? auto_seed_q : seed_value_i;
    end else begin
      if (cmd_i.fill_step) begin
        v_q <= fill_word;
      end
      if (cmd_i.commit) begin
        cur_q <= nxt_word_q;
      end
    end
    if (cmd_i.rd_far) begin
      y_q        <= {cur_q[31], rd_q[30:0]};
      nxt_word_q <= rd_q;
    end
    if (cmd_i.commit) begin
      word_q <= mt_pkg::temper(twist_word);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

endmodule

// File: rtl/mersenne_twister_generator.sv
// top level of the mt19937 generator: controller, datapath and channel wiring
//
//   port   | direction | moves                         | handshake
//   -------+-----------+-------------------------------+-------------
//   in_i   | in        | operation, seed_value item    | valid/ready
//   out_o  | out       | random_word item              | valid/ready
//   cfg_i  | in        | auto seed write               | valid/ready
//
// a next item runs accept with next-word read, far-word read, then twist and write back
// the word at the current index stays cached, so only two memory reads remain
// a seed item runs accept, then a fill sweep over every state word, one word a cycle
// a next item before any seed runs accept, the sweep, then the next-word read, far-word read and twist
// reset leaves the block unseeded; the state memory needs no clearing pass
// a waiting result stalls the twist cycle only; cfg_i is always ready
module mersenne_twister_generator #(
  parameter int unsigned STATE_WORDS  = mt_pkg::STATE_WORDS,
  parameter int unsigned TWIST_OFFSET = mt_pkg::TWIST_OFFSET
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mt_item_if.sink  in_i,
  mt_word_if.source out_o,
  mt_cfg_if.sink   cfg_i
);

  mt_pkg::mt_cmd_t cmd;
  mt_pkg::mt_sts_t sts;

  assign cfg_i.ready = 1'b1;

  // sequencing
  mt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_operation_i (in_i.operation),
    .in_ready_o     (in_i.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // state memory and arithmetic
  mt_dpath #(
    .STATE_WORDS  (STATE_WORDS),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .seed_value_i  (in_i.seed_value),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .random_word_o (out_o.random_word)
  );

`ifndef SYNTH
  // no datapath command competes with taking a new item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fill_step || cmd.rd_far || cmd.commit) |-> !in_i.ready)
    else $error("datapath busy while input ready");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten");

  // an accepted seed item starts a fill sweep in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (mt_pkg::op_e'(in_i.operation) == mt_pkg::OP_SEED))
    |=> cmd.fill_step)
    else $error("seed item did not start fill");

  // a fill sweep never overlaps a memory read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill_step |-> !(cmd.rd_nxt || cmd.rd_far))
    else $error("fill overlaps read");
`endif

endmodule

// File: tb/sv/mersenne_twister_generator_test.sv
// testbench for the mt19937 generator: directed table, random streams, word-by-word checking
module mersenne_twister_generator_test;

  localparam int unsigned LIMIT_CYCLES  = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 700;   // covers a full fill sweep
  localparam int unsigned HOLD_CYCLES   = 400;   // long receiver stall
  localparam int unsigned HOLD_AT       = 250;   // result count that triggers it
  localparam int unsigned DIR_ROWS_N    = 18;
  localparam int unsigned LONG_RUN      = 630;   // next items past one index wrap

  // one row of the directed table
  typedef struct packed {
    mt_pkg::op_e op;
    logic [31:0] seed;
    logic        known;
    logic [31:0] word;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // unseeded after reset: self-seeds from the default auto seed
    '{mt_pkg::OP_NEXT, 32'hFFFF_FFFF, 1'b1, 32'd3499211612},
    '{mt_pkg::OP_NEXT, 32'h0000_0000, 1'b1, 32'd581869302},
    '{mt_pkg::OP_NEXT, 32'h5A5A_5A5A, 1'b1, 32'd3890346734},
    '{mt_pkg::OP_SEED, 32'h0000_0001, 1'b0, 32'h0},
    '{mt_pkg::OP_NEXT, 32'hA5A5_A5A5, 1'b1, 32'd1791095845},
    '{mt_pkg::OP_NEXT, 32'h0000_0000, 1'b0, 32'h0},
    '{mt_pkg::OP_SEED, 32'h0000_0000, 1'b0, 32'h0},
    '{mt_pkg::OP_NEXT, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{mt_pkg::OP_SEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{mt_pkg::OP_NEXT, 32'h0000_0000, 1'b0, 32'h0},
    '{mt_pkg::OP_NEXT, 32'hFFFF_FFFF, 1'b0, 32'h0},
    // back-to-back seeds, the second one wins
    '{mt_pkg::OP_SEED, 32'h8000_0000, 1'b0, 32'h0},
    '{mt_pkg::OP_SEED, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{mt_pkg::OP_NEXT, 32'h1234_5678, 1'b0, 32'h0},
    // reseed mid-stream restarts the sequence from the top
    '{mt_pkg::OP_SEED, 32'd5489,      1'b0, 32'h0},
    '{mt_pkg::OP_NEXT, 32'h0000_0000, 1'b1, 32'd3499211612},
    '{mt_pkg::OP_NEXT, 32'hFFFF_FFFF, 1'b1, 32'd581869302},
    '{mt_pkg::OP_NEXT, 32'hC3C3_C3C3, 1'b0, 32'h0}
  };

  logic clk_i;
  logic rst_ni;

  mt_item_if in_if ();
  mt_word_if out_if ();
  mt_cfg_if  cfg_if ();

  mersenne_twister_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predicted generator state
  logic [31:0] mt_state [mt_pkg::STATE_WORDS];
  logic [9:0]  state_idx;
  logic [31:0] auto_seed_shadow;

  // expected words, oldest first
  logic [31:0] word_q [$];

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned sent_count;
  bit          send_burst;
  bit          recv_burst;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // output tempering of a freshly twisted word
  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] s1, s2, s3;
    s1 = w ^ {11'b0, w[31:11]};
    s2 = s1 ^ ({s1[24:0], 7'b0} & mt_pkg::TEMPER_B);
    s3 = s2 ^ ({s2[16:0], 15'b0} & mt_pkg::TEMPER_C);
    return s3 ^ {18'b0, s3[31:18]};
  endfunction

  // initialisation recurrence over the whole state
  function automatic void fill_from_seed(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    mt_state[0] = v;
    for (int i = 1; i < mt_pkg::STATE_WORDS; i++) begin
      v = mt_pkg::SEED_MULT * (v ^ (v >> 30)) + 32'(i);
      mt_state[i] = v;
    end
    state_idx = '0;
  endfunction

  // regenerate the word at the index and return it tempered
  function automatic logic [31:0] twist_next();
    int unsigned cur, nxt, far_i;
    logic [31:0] y, w;
    if (state_idx >= mt_pkg::STATE_WORDS) fill_from_seed(auto_seed_shadow);
    cur   = 32'(state_idx);
    nxt   = (cur + 1) % mt_pkg::STATE_WORDS;
    far_i = (cur + mt_pkg::TWIST_OFFSET) % mt_pkg::STATE_WORDS;
    y = {mt_state[cur][31], mt_state[nxt][30:0]};
    w = mt_state[far_i] ^ (y >> 1) ^ (y[0] ? mt_pkg::TWIST_MATRIX : 32'h0);
    mt_state[cur] = w;
    state_idx = 10'(nxt);
    return temper_word(w);
  endfunction

  // offer one item after a random gap and wait for it to be taken
  task automatic send_item(input mt_pkg::op_e op, input logic [31:0] seed,
                           input logic known, input logic [31:0] known_word);
    int unsigned gap;
    logic [31:0] w;
    if (sent_count % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.seed_value <= seed;
    do @(posedge clk_i); while (!in_if.ready);
    sent_count++;
    if (op == mt_pkg::OP_SEED) begin
      fill_from_seed(seed);
    end else begin
      w = twist_next();
      word_q.push_back(known ? known_word : w);
    end
  endtask

  // seed value with the extremes drawn now and then
  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // streams of a seed and a run of next items, with some continued and doubled seeds
  task automatic run_mixed(input int unsigned n_items);
    int unsigned left, run_len;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item(mt_pkg::OP_SEED, pick_seed(), 1'b0, 32'h0);
        left--;
      end
      if (left > 0 && $urandom_range(0, 9) == 0) begin
        send_item(mt_pkg::OP_SEED, pick_seed(), 1'b0, 32'h0);
        left--;
      end
      run_len = $urandom_range(0, 24);
      while (run_len > 0 && left > 0) begin
        send_item(mt_pkg::OP_NEXT, $urandom(), 1'b0, 32'h0);
        run_len--;
        left--;
      end
    end
  endtask

  // wait for all words, then for any fill still under way
  task automatic settle();
    in_if.valid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write the auto seed register
  task automatic write_auto_seed(input logic [31:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    auto_seed_shadow = v;
  endtask

  // receiver: random stalls, one long hold, checks each word
  initial begin
    logic [31:0] want;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (results_seen % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 6);
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      results_seen++;
      if (word_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected word %h with nothing pending", out_if.random_word);
      end else begin
        want = word_q.pop_front();
        if (out_if.random_word !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("word %0d: expected %h, got %h", results_seen, want,
                     out_if.random_word);
        end
      end
    end
  end

  // main sequence
  initial begin
    mt_state         = '{default: 32'h0};
    state_idx        = 10'(mt_pkg::STATE_WORDS);
    auto_seed_shadow = mt_pkg::DEFAULT_SEED;
    error_count      = 0;
    results_seen     = 0;
    sent_count       = 0;
    send_burst       = 1'b0;
    recv_burst       = 1'b0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= mt_pkg::OP_NEXT;
    in_if.seed_value <= '0;
    out_if.ready     <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < DIR_ROWS_N; r++)
      send_item(DIR_ROWS[r].op, DIR_ROWS[r].seed, DIR_ROWS[r].known, DIR_ROWS[r].word);
    settle();

    // short mixed streams
    write_auto_seed(32'h0000_0000);
    run_mixed(100);
    settle();

    // one long stream past the index wrap, with the receiver hold inside it
    write_auto_seed(32'hFFFF_FFFF);
    send_item(mt_pkg::OP_SEED, $urandom(), 1'b0, 32'h0);
    repeat (LONG_RUN) send_item(mt_pkg::OP_NEXT, $urandom(), 1'b0, 32'h0);
    settle();

    // more mixed streams
    write_auto_seed($urandom());
    run_mixed(100);
    settle();

    if (error_count == 0 && word_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: mersenne_twister_generator.f
rtl/mt_pkg.sv
rtl/mt_if.sv
rtl/mt_ctrl.sv
rtl/mt_dpath.sv
rtl/mersenne_twister_generator.sv
tb/sv/mersenne_twister_generator_test.sv
